@@ rtl/clns_pkg.sv @@
// Shared types, constants and helper functions for the character-LCD nibble sequencer.
// Depends on nothing; every other file of the block imports it.
package clns_pkg;

  // Field widths and sizes.
  localparam int NUMBER_W    = 32;
  localparam int MAX_DIGITS  = 10;
  localparam int BCD_DIGITS  = 10;
  localparam int EMIT_DIGITS = (MAX_DIGITS < BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;
  localparam int DIGIT_IDX_W = $clog2(BCD_DIGITS);
  localparam int STEP_W      = $clog2(NUMBER_W);
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

  // Bus constants.
  localparam logic [7:0] SET_ADDR_OPCODE = 8'h80;
  localparam logic [7:0] SECOND_ROW_BASE = 8'h40;
  localparam logic [7:0] FIRST_ROW_BASE  = 8'h00;
  localparam logic [7:0] ASCII_ZERO      = 8'h30;

  // Configuration register indexes.
  localparam logic CFG_LINE_COUNT   = 1'b0;
  localparam logic CFG_COLUMN_COUNT = 1'b1;

  typedef enum logic [1:0] {
    OP_COMMAND = 2'd0,
    OP_DATA    = 2'd1,
    OP_CURSOR  = 2'd2,
    OP_NUMBER  = 2'd3
  } clns_op_t;

  // One byte queued for the bus, with its register select and end marker.
  typedef struct packed {
    logic [7:0] value;
    logic       rs;
    logic       last;
  } clns_entry_t;

  // Set-address command for a cursor position, row clamped to the line count.
  function automatic logic [7:0] cursor_address(input logic [5:0] col,
                                                input logic [1:0] row,
                                                input logic [2:0] line_cnt,
                                                input logic [5:0] col_cnt);
    logic [2:0] lines;
    logic [1:0] r;
    logic [7:0] off;
    lines = (line_cnt == 3'd0) ? 3'd1 : line_cnt;
    r     = row;
    if ({1'b0, row} >= lines) begin
      r = 2'(lines - 3'd1);
    end
    case (r)
      2'd0:    off = FIRST_ROW_BASE;
      2'd1:    off = SECOND_ROW_BASE;
      2'd2:    off = FIRST_ROW_BASE + {2'b00, col_cnt};
      default: off = SECOND_ROW_BASE + {2'b00, col_cnt};
    endcase
    return SET_ADDR_OPCODE | ({2'b00, col} + off);
  endfunction

endpackage

@@ rtl/char_lcd_nibble_sequencer.sv @@
// Top level of the character-LCD nibble sequencer: configuration registers and glue.
// Depends on clns_pkg, clns_front, clns_fifo and clns_back.
//
//  Channel  | Handshake               | Payload
//  ---------+-------------------------+---------------------------------------------
//  request  | start / busy            | in_op, in_byte_value, in_column, in_row,
//           |                         | in_number
//  result   | out_strobe (one cycle)  | out_nibble, out_register_select, out_last
//  config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A command, data or cursor request gives two transfers; each byte passes through the queue,
// the back end's byte register and the output registers, and busy drops with the last one.
// A number request passes through the binary to BCD converter, then a step finding the
// leading digit, then two transfers per digit: up to twenty transfers for ten digits.
// Synchronous active-low reset returns line_count to 2 and column_count to 16.
// The receiver cannot stall; results flow through a four-entry byte queue.
module char_lcd_nibble_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_byte_value,
  input  logic [5:0]  in_column,
  input  logic [1:0]  in_row,
  input  logic [31:0] in_number,
  output logic        out_strobe,
  output logic [3:0]  out_nibble,
  output logic        out_register_select,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);
  import clns_pkg::*;

  logic [2:0]  line_count_r;
  logic [5:0]  column_count_r;
  logic        accept;
  logic        front_busy;
  logic        push;
  clns_entry_t push_entry;
  logic        fifo_full;
  logic        fifo_empty;
  logic        pop;
  clns_entry_t pop_entry;
  logic        back_active;

  // Configuration transactions are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r   <= 3'd2;
      column_count_r <= 6'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LINE_COUNT:   line_count_r   <= cfg_data[2:0];
        CFG_COLUMN_COUNT: column_count_r <= cfg_data;
        default:          line_count_r   <= line_count_r;
      endcase
    end
  end

  // Busy until every byte of the current request has left the back end.
  assign busy   = front_busy || !fifo_empty || back_active;
  assign accept = start && !busy;

  clns_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .op           (in_op),
    .byte_value   (in_byte_value),
    .column       (in_column),
    .row          (in_row),
    .number       (in_number),
    .line_count   (line_count_r),
    .column_count (column_count_r),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_entry   (push_entry),
    .front_busy   (front_busy)
  );

  clns_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (fifo_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (fifo_empty)
  );

  clns_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .fifo_empty          (fifo_empty),
    .fifo_entry          (pop_entry),
    .pop                 (pop),
    .active              (back_active),
    .out_strobe          (out_strobe),
    .out_nibble          (out_nibble),
    .out_register_select (out_register_select),
    .out_last            (out_last)
  );

  // A transfer that does not end its request means the request is still in progress.
  a_busy_mid_request: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |-> busy)
    else $error("busy low while a request still has transfers to send");

  // Nothing is in flight when a request is accepted, so no transfer follows at once.
  a_no_stray_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !out_strobe)
    else $error("transfer appeared right after a request was accepted");

  // The front end never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_full)
    else $error("byte queue written while full");

endmodule

@@ rtl/clns_front.sv @@
// Front end: accepts requests, classifies them and queues bus bytes.
// Numbers go through a shift-and-add-3 binary to BCD converter. Uses clns_pkg.
module clns_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [1:0]           op,
  input  logic [7:0]           byte_value,
  input  logic [5:0]           column,
  input  logic [1:0]           row,
  input  logic [31:0]          number,
  input  logic [2:0]           line_count,
  input  logic [5:0]           column_count,
  input  logic                 fifo_full,
  output logic                 push,
  output clns_pkg::clns_entry_t push_entry,
  output logic                 front_busy
);
  import clns_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_CONV, F_SCAN, F_EMIT} front_state_t;

  front_state_t                  state_r;
  logic [BCD_DIGITS-1:0][3:0]    bcd_r;
  logic [NUMBER_W-1:0]           bin_r;
  logic [STEP_W-1:0]             step_r;
  logic [DIGIT_IDX_W-1:0]        idx_r;

  logic [BCD_DIGITS-1:0][3:0]    adj;
  logic [4*BCD_DIGITS-1:0]       adj_flat;
  logic [BCD_DIGITS-1:0][3:0]    bcd_nxt;
  logic [NUMBER_W-1:0]           bin_nxt;
  logic [DIGIT_IDX_W-1:0]        scan_idx;
  clns_op_t                      op_t;

  assign op_t = clns_op_t'(op);

  // One conversion step: correct every digit of five or more, then shift left.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? (bcd_r[i] + 4'd3) : bcd_r[i];
    end
    adj_flat = adj;
    bcd_nxt  = {adj_flat[4*BCD_DIGITS-2:0], bin_r[NUMBER_W-1]};
    bin_nxt  = {bin_r[NUMBER_W-2:0], 1'b0};
  end

  // Highest significant digit, at least the units digit, capped to the printed width.
  always_comb begin
    scan_idx = '0;
    for (int i = 1; i < BCD_DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) begin
        scan_idx = DIGIT_IDX_W'(i);
      end
    end
    if (scan_idx > DIGIT_IDX_W'(EMIT_DIGITS - 1)) begin
      scan_idx = DIGIT_IDX_W'(EMIT_DIGITS - 1);
    end
  end

  // Queue writes: single bytes straight from the request, digits from the converter.
  always_comb begin
    push       = 1'b0;
    push_entry = '0;
    case (state_r)
      F_IDLE: begin
        if (accept && (op_t != OP_NUMBER)) begin
          push            = 1'b1;
          push_entry.last = 1'b1;
          case (op_t)
            OP_COMMAND: begin
              push_entry.value = byte_value;
              push_entry.rs    = 1'b0;
            end
            OP_DATA: begin
              push_entry.value = byte_value;
              push_entry.rs    = 1'b1;
            end
            default: begin
              push_entry.value = cursor_address(column, row, line_count, column_count);
              push_entry.rs    = 1'b0;
            end
          endcase
        end
      end
      F_EMIT: begin
        push             = !fifo_full;
        push_entry.value = ASCII_ZERO + {4'b0000, bcd_r[idx_r]};
        push_entry.rs    = 1'b1;
        push_entry.last  = (idx_r == '0);
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Sequencer for number requests.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept && (op_t == OP_NUMBER)) begin
            bin_r   <= number;
            bcd_r   <= '0;
            step_r  <= '0;
            state_r <= F_CONV;
          end
        end
        F_CONV: begin
          bcd_r  <= bcd_nxt;
          bin_r  <= bin_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(NUMBER_W - 1)) begin
            state_r <= F_SCAN;
          end
        end
        F_SCAN: begin
          idx_r   <= scan_idx;
          state_r <= F_EMIT;
        end
        F_EMIT: begin
          if (!fifo_full) begin
            if (idx_r == '0) begin
              state_r <= F_IDLE;
            end else begin
              idx_r <= idx_r - 1'b1;
            end
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

  assign front_busy = (state_r != F_IDLE);

endmodule

@@ rtl/clns_fifo.sv @@
// Short byte queue between the front end and the bus sequencer.
// Uses clns_pkg for the entry type and depth.
module clns_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  clns_pkg::clns_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output clns_pkg::clns_entry_t pop_entry,
  output logic                  empty
);
  import clns_pkg::*;

  clns_entry_t             mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [FIFO_PTR_W:0]     count_r;
  logic                    do_push;
  logic                    do_pop;

  assign full    = (count_r == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign pop_entry = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/clns_back.sv @@
// Back end: splits each queued byte into two bus transfers, high nibble first.
// Uses clns_pkg for the entry type.
module clns_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fifo_empty,
  input  clns_pkg::clns_entry_t fifo_entry,
  output logic                  pop,
  output logic                  active,
  output logic                  out_strobe,
  output logic [3:0]            out_nibble,
  output logic                  out_register_select,
  output logic                  out_last
);
  import clns_pkg::*;

  logic        active_r;
  logic        phase_r;
  clns_entry_t cur_r;
  logic        strobe_r;
  logic [3:0]  nibble_r;
  logic        rs_r;
  logic        last_r;

  // A new byte is taken when nothing is in flight or the low nibble goes out now.
  assign pop = !fifo_empty && (!active_r || phase_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      phase_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= active_r;
      if (active_r) begin
        nibble_r <= phase_r ? cur_r.value[3:0] : cur_r.value[7:4];
        rs_r     <= cur_r.rs;
        last_r   <= phase_r && cur_r.last;
      end
      if (pop) begin
        cur_r    <= fifo_entry;
        active_r <= 1'b1;
        phase_r  <= 1'b0;
      end else if (active_r) begin
        if (phase_r) begin
          active_r <= 1'b0;
        end
        phase_r <= !phase_r;
      end
    end
  end

  assign active              = active_r;
  assign out_strobe          = strobe_r;
  assign out_nibble          = nibble_r;
  assign out_register_select = rs_r;
  assign out_last            = last_r;

endmodule
